FILE: hdl/rss_pkg.sv
// Shared types, constants and helpers of the rotated sorted search core.
`default_nettype none

package rss_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Fixed field widths
   localparam int VAL_W = 32;
   localparam int POS_W = 10;
   localparam int EIX_W = 10;
   localparam int CSR_W = 11;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef logic signed [VAL_W-1:0] value_type;

   // Table port request from the sequencer
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] wdata;
   } ram_req_type;

   // Finished search result from the sequencer
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } result_type;

   // Midpoint of the half-open interval [lo, up), with up above lo
   function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] up);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, up} - (CNT_W + 1)'(1);
      return sum[IDX_W:1];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/rss_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module rss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write at the addressed entry, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/rss_seq.sv
// Search sequencer: walks the binary search through reads of the value table.
`default_nettype none

module rss_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_cmd,
   input  wire logic [rss_pkg::EIX_W-1:0] req_entry_index,
   input  wire rss_pkg::value_type        req_entry_value,
   input  wire rss_pkg::value_type        req_search_key,
   input  wire logic [rss_pkg::CNT_W-1:0] count,
   input  wire logic                      out_free,
   input  wire rss_pkg::value_type        ram_rdata,
   output      rss_pkg::ram_req_type      ram_req,
   output      rss_pkg::result_type       result,
   output      logic                      idle
);

   import rss_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MID  = 3'd1;
   localparam logic [2:0] S_LO   = 3'd2;
   localparam logic [2:0] S_HI   = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] up_ff, up_in;
   value_type        key_ff, key_in;
   value_type        vm_ff, vm_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [IDX_W-1:0] mid;
   logic [CNT_W-1:0] mid_next;
   logic [CNT_W-1:0] nlo, nup;
   logic             advance;

   assign mid      = mid_of(lo_ff, up_ff);
   assign mid_next = CNT_W'(mid) + CNT_W'(1);

   // Step the search: one table read per cycle
   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      up_in    = up_ff;
      key_in   = key_ff;
      vm_in    = vm_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      nlo      = lo_ff;
      nup      = up_ff;
      advance  = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.addr  = mid;
      ram_req.wdata = req_entry_value;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  // Store the entry; drop indexes beyond the table
                  ram_req.we   = (32'(req_entry_index) < 32'(MAX_ENTRIES));
                  ram_req.addr = IDX_W'(req_entry_index);
               end else begin
                  key_in  = req_search_key;
                  nlo     = '0;
                  nup     = count;
                  advance = 1'b1;
               end
            end
         end
         S_MID: begin
            if (key_ff == ram_rdata) begin
               found_in = 1'b1;
               pos_in   = POS_W'(mid);
               state_in = S_DONE;
            end else begin
               vm_in        = ram_rdata;
               ram_req.addr = lo_ff[IDX_W-1:0];
               state_in     = S_LO;
            end
         end
         S_LO: begin
            if (ram_rdata <= vm_ff) begin
               // Left half sorted
               if (key_ff >= ram_rdata && key_ff < vm_ff) begin
                  nup = CNT_W'(mid);
               end else begin
                  nlo = mid_next;
               end
               advance = 1'b1;
            end else begin
               ram_req.addr = IDX_W'(up_ff - CNT_W'(1));
               state_in     = S_HI;
            end
         end
         S_HI: begin
            // Right half sorted
            if (key_ff > vm_ff && key_ff <= ram_rdata) begin
               nlo = mid_next;
            end else begin
               nup = CNT_W'(mid);
            end
            advance = 1'b1;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Narrow the interval and read the next midpoint, or finish empty
      if (advance) begin
         lo_in        = nlo;
         up_in        = nup;
         ram_req.addr = mid_of(nlo, nup);
         if (nlo < nup) begin
            state_in = S_MID;
         end else begin
            found_in = 1'b0;
            pos_in   = '0;
            state_in = S_DONE;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold search payload
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      up_ff    <= up_in;
      key_ff   <= key_in;
      vm_ff    <= vm_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign result.valid    = (state_ff == S_DONE);
   assign result.found    = found_ff;
   assign result.position = pos_ff;

endmodule

`default_nettype wire

FILE: hdl/rotated_sorted_search_core.sv
// Top level of the rotated sorted search core: table RAM, sequencer, result register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_stall, cmd, index, value, key | in
//  rsp     | rsp_valid/rsp_stall, found, position    | out
//  csr     | csr_wr_en, csr_wr_data (entry_count)    | in
//
// A write item is taken in the idle state, which the sequencer keeps. A search reads
// the midpoint and the low end per halving step, and the high end as well when the
// right half is the sorted one, then hands off its result from the done state before
// the next item is taken; the single table port sets that order.
// The result register frees the sequencer, so the next item is taken while a
// result still waits under rsp_stall. Reset clears control and entry_count only;
// the table has no clearing pass and reads are valid only after writes.
`default_nettype none

module rotated_sorted_search_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic                      req_cmd,
   input  wire logic [rss_pkg::EIX_W-1:0] req_entry_index,
   input  wire logic signed [rss_pkg::VAL_W-1:0] req_entry_value,
   input  wire logic signed [rss_pkg::VAL_W-1:0] req_search_key,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic                      rsp_found,
   output      logic [rss_pkg::POS_W-1:0] rsp_position,
   input  wire logic                      csr_wr_en,
   input  wire logic [rss_pkg::CSR_W-1:0] csr_wr_data
);

   import rss_pkg::*;

   logic [CSR_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] count_sat;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_position_ff, rsp_position_in;

   ram_req_type      ram_req;
   logic [VAL_W-1:0] ram_rdata;
   result_type       result;
   logic             idle;
   logic             out_free;
   logic             load;

   // Hold the entry count, saturate to the table size
   assign entry_count_in = csr_wr_en ? csr_wr_data : entry_count_ff;
   assign count_sat = (32'(entry_count_ff) > 32'(MAX_ENTRIES)) ?
                      CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   rss_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   rss_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .count           (count_sat),
      .out_free        (out_free),
      .ram_rdata       ($signed(ram_rdata)),
      .ram_req         (ram_req),
      .result          (result),
      .idle            (idle)
   );

   assign req_stall = !idle;

   // Load the result register when it is empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = result.valid && out_free;

   assign rsp_valid_in    = load || (rsp_valid_ff && rsp_stall);
   assign rsp_found_in    = load ? result.found : rsp_found_ff;
   assign rsp_position_in = load ? result.position : rsp_position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

`ifndef SYNTHESIS
   // Table writes come only from accepted write items
   a_write_from_item: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (req_valid && !req_stall && req_cmd == CMD_WRITE))
      else $error("table written without a write item");

   // A miss reports position zero
   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_position_ff == '0))
      else $error("miss with nonzero position");

   // A loaded result appears on the port in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && rsp_found == $past(result.found)
                && rsp_position == $past(result.position)))
      else $error("result register did not take the result");

   // A finished result never overwrites one still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("result register overwritten under stall");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for rotated_sorted_search_core: table writes and key searches checked against a predictor.
`timescale 1ns / 100ps

module testbench;
   import rss_pkg::*;

   localparam int        RANDOM_ITEMS   = 520;
   localparam int        SETTLE_CYCLES  = 64;
   localparam int        END_WAIT_LIMIT = 4000;
   localparam int        CYCLE_LIMIT    = 800_000;
   localparam value_type MIN_VALUE      = 32'sh8000_0000;
   localparam value_type MAX_VALUE      = 32'sh7fff_ffff;

   // Shapes of table contents loaded before a round of searches
   typedef enum {ROW_ROTATED, ROW_UNROTATED, ROW_REPEATS, ROW_NOISE} row_style_type;
   // Receiver behavior on the result channel
   typedef enum {STALL_NONE, STALL_HOLD, STALL_RANDOM} stall_mode_type;

   typedef struct packed {
      value_type        key;
      logic             found;
      logic [POS_W-1:0] position;
   } search_answer_type;

   // Keeps a shadow of the table and entry_count, predicts each search answer
   class search_tracker_type;
      value_type             value_mem[MAX_ENTRIES];
      logic [CSR_W-1:0]      entry_count;
      search_answer_type     awaited_answers[$];
      int                    errors;
      int                    writes_seen;
      int                    searches_seen;
      int                    hits_seen;
      int                    answers_checked;

      function new();
         entry_count     = '0;
         errors          = 0;
         writes_seen     = 0;
         searches_seen   = 0;
         hits_seen       = 0;
         answers_checked = 0;
      endfunction

      // Apply a write to the shadow table, or predict the answer of a search
      function void note_item(logic cmd, logic [EIX_W-1:0] index, value_type value,
                              value_type key);
         search_answer_type answer;
         int                live, lo, hi, mid;
         value_type         at_mid, at_lo, at_hi;
         if (cmd == CMD_WRITE) begin
            value_mem[index] = value;
            writes_seen++;
         end else begin
            answer     = '0;
            answer.key = key;
            live = (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count);
            lo   = 0;
            hi   = live - 1;
            // narrow toward the half that is sorted and can hold the key
            while (lo <= hi && !answer.found) begin
               mid    = lo + (hi - lo) / 2;
               at_mid = value_mem[mid];
               if (key == at_mid) begin
                  answer.found    = 1'b1;
                  answer.position = POS_W'(mid);
               end else begin
                  at_lo = value_mem[lo];
                  if (at_lo <= at_mid) begin
                     if (key >= at_lo && key < at_mid) hi = mid - 1;
                     else lo = mid + 1;
                  end else begin
                     at_hi = value_mem[hi];
                     if (key > at_mid && key <= at_hi) lo = mid + 1;
                     else hi = mid - 1;
                  end
               end
            end
            awaited_answers.push_back(answer);
            searches_seen++;
            if (answer.found) hits_seen++;
         end
      endfunction

      // Compare one delivered answer with the oldest prediction
      function void check_result(logic found, logic [POS_W-1:0] position);
         search_answer_type want;
         if (awaited_answers.size() == 0) begin
            $error("result with no search outstanding: found %0d position %0d",
                   found, position);
            errors++;
         end else begin
            want = awaited_answers.pop_front();
            answers_checked++;
            if (found !== want.found) begin
               $error("found (key %0d): expected %0d, actual %0d", want.key, want.found, found);
               errors++;
            end
            if (position !== want.position) begin
               $error("position (key %0d): expected %0d, actual %0d", want.key,
                      want.position, position);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_cmd         = CMD_WRITE;
   logic [EIX_W-1:0]   req_entry_index = '0;
   value_type          req_entry_value = '0;
   value_type          req_search_key  = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic               rsp_found;
   logic [POS_W-1:0]   rsp_position;
   logic               csr_wr_en       = 1'b0;
   logic [CSR_W-1:0]   csr_wr_data     = '0;

   search_tracker_type tracker;
   bit                 entry_written[MAX_ENTRIES];
   int                 burst_left      = 0;
   int                 items_sent      = 0;
   int                 count_settings  = 0;
   int                 cycle_count     = 0;
   int                 stall_run       = 0;
   stall_mode_type     stall_mode      = STALL_NONE;

   rotated_sorted_search_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** rotated_sorted_search_core: FAILED **");
         $finish;
      end
   end

   // Stall the result channel in stretches: free, held, or random per cycle
   always @(posedge clock) begin
      if (stall_run == 0) begin
         case ($urandom_range(2))
            0:       stall_mode = STALL_NONE;
            1:       stall_mode = STALL_HOLD;
            default: stall_mode = STALL_RANDOM;
         endcase
         stall_run = (stall_mode == STALL_NONE) ? $urandom_range(80, 10) : $urandom_range(30, 1);
      end
      stall_run--;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_HOLD:   rsp_stall <= 1'b1;
         default:      rsp_stall <= ($urandom_range(1) == 1);
      endcase
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_found, rsp_position);
   end

   // Present one item, in bursts with random gaps, and hold it until accepted
   task automatic send_item(input logic cmd, input logic [EIX_W-1:0] index,
                            input value_type value, input value_type key);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         burst_left = $urandom_range(16, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= index;
      req_entry_value <= value;
      req_search_key  <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_WRITE) entry_written[index] = 1'b1;
      items_sent++;
      tracker.note_item(cmd, index, value, key);
   endtask

   // Drop valid, wait for all answers, then let a trailing write finish
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (tracker.awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write entry_count while the block is idle
   task automatic set_entry_count(input logic [CSR_W-1:0] count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.entry_count = count;
      count_settings++;
   endtask

   // Load entries 0..n-1 with a row of the given shape, sorted unless noise, rotated at random unless unrotated
   task automatic fill_table(input int n, input row_style_type style);
      longint    step_max, room, acc;
      int        rot, first, idx;
      value_type row[$];
      if (n == 0) return;
      case ($urandom_range(3))
         0:       step_max = 1;
         1:       step_max = 4;
         2:       step_max = 1000;
         default: step_max = 64'h1_0000_0000 / (n + 1);
      endcase
      if (style == ROW_REPEATS) step_max = 3;
      room = 64'hFFFF_FFFF - longint'(n) * step_max;
      acc  = longint'(MIN_VALUE);
      if ($urandom_range(4) != 0) acc += {32'd0, $urandom} % (room + 1);
      for (int i = 0; i < n; i++) begin
         case (style)
            ROW_NOISE:   row.push_back(value_type'($urandom));
            ROW_REPEATS: begin
               row.push_back(value_type'(acc));
               acc += $urandom_range(2);
            end
            default: begin
               row.push_back(value_type'(acc));
               acc += ({32'd0, $urandom} % step_max) + 1;
            end
         endcase
      end
      rot   = (style == ROW_UNROTATED || n == 1) ? 0 : $urandom_range(n - 1);
      first = $urandom_range(n - 1);
      // write in wrapped order, with stray writes above the row now and then
      for (int k = 0; k < n; k++) begin
         idx = (first + k) % n;
         send_item(CMD_WRITE, EIX_W'(idx), row[(idx + rot) % n], value_type'($urandom));
         if (n < MAX_ENTRIES && $urandom_range(9) == 0)
            send_item(CMD_WRITE, EIX_W'($urandom_range(MAX_ENTRIES - 1, n)),
                      value_type'($urandom), value_type'($urandom));
      end
   endtask

   // Searches for stored keys, near misses, extremes and random keys, with a stray write now and then
   task automatic run_searches(input int num);
      int        live, pick;
      value_type key;
      live = (tracker.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(tracker.entry_count);
      repeat (num) begin
         pick = $urandom_range(19);
         if (live != 0 && pick <= 13) key = tracker.value_mem[$urandom_range(live - 1)];
         else key = value_type'($urandom);
         case (pick)
            11, 12:  key = key + 1;
            13:      key = key - 1;
            16:      key = MIN_VALUE;
            17:      key = MAX_VALUE;
            19:      key = '0;
            default: ;
         endcase
         if (pick == 18)
            send_item(CMD_WRITE, EIX_W'($urandom), value_type'($urandom), key);
         else
            send_item(CMD_SEARCH, EIX_W'($urandom), value_type'($urandom), key);
      end
   endtask

   initial begin : stimulus
      value_type     row[$];
      value_type     probe;
      int            random_start, prefix, n, pick, end_wait, budget;
      row_style_type style;

      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, then a rotated row holding both extremes
      set_entry_count('0);
      send_item(CMD_SEARCH, '0, '0, '0);
      row = '{32'sd5, 32'sd100, MAX_VALUE, MIN_VALUE, -32'sd7, 32'sd0, 32'sd1, 32'sd3};
      foreach (row[i]) send_item(CMD_WRITE, EIX_W'(i), row[i], '0);
      set_entry_count(CSR_W'(8));
      send_item(CMD_SEARCH, '0, '0, MIN_VALUE);
      send_item(CMD_SEARCH, '0, '0, MAX_VALUE);
      send_item(CMD_SEARCH, '0, '0, 32'sd5);
      send_item(CMD_SEARCH, '0, '0, 32'sd3);
      send_item(CMD_SEARCH, '0, '0, 32'sd2);
      send_item(CMD_SEARCH, '0, '0, -32'sd8);
      // single-entry window
      set_entry_count(CSR_W'(1));
      send_item(CMD_SEARCH, '0, '0, 32'sd5);
      send_item(CMD_SEARCH, '0, '0, 32'sd100);
      // repeated values break the rotated order
      send_item(CMD_WRITE, EIX_W'(2), 32'sd100, '0);
      send_item(CMD_WRITE, EIX_W'(3), 32'sd100, '0);
      set_entry_count(CSR_W'(8));
      send_item(CMD_SEARCH, '0, '0, 32'sd100);
      send_item(CMD_SEARCH, '0, '0, -32'sd7);
      send_item(CMD_SEARCH, '0, '0, 32'sd4);

      // Random rounds: load a row or reuse the table, set the window, search
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(3) == 0) begin
            prefix = 0;
            while (prefix < MAX_ENTRIES && entry_written[prefix]) prefix++;
            set_entry_count(CSR_W'($urandom_range(prefix)));
         end else begin
            pick = $urandom_range(99);
            if (pick < 5) n = 0;
            else if (pick < 65) n = $urandom_range(16, 1);
            else if (pick < 90) n = $urandom_range(64, 17);
            else n = $urandom_range(256, 65);
            // keep the row within what is left of the item budget
            budget = RANDOM_ITEMS - (items_sent - random_start);
            if (n > budget) n = budget;
            pick = $urandom_range(9);
            if (pick < 6) style = ROW_ROTATED;
            else if (pick == 6) style = ROW_UNROTATED;
            else if (pick == 7) style = ROW_REPEATS;
            else style = ROW_NOISE;
            fill_table(n, style);
            set_entry_count(CSR_W'(($urandom_range(7) == 0) ? $urandom_range(n) : n));
         end
         run_searches($urandom_range(12, 4));
      end

      // Count above the table size, then exactly the size: the first midpoint
      // of a full-size window is the middle entry, so a hit there reads nothing else
      probe = value_type'($urandom);
      send_item(CMD_WRITE, EIX_W'(MAX_ENTRIES / 2 - 1), probe, '0);
      set_entry_count('1);
      send_item(CMD_SEARCH, '0, '0, probe);
      set_entry_count(CSR_W'(MAX_ENTRIES));
      send_item(CMD_SEARCH, '0, '0, probe);

      // Wait out the last answers, bounded
      req_valid <= 1'b0;
      end_wait  = 0;
      while (tracker.awaited_answers.size() != 0 && end_wait < END_WAIT_LIMIT) begin
         @(posedge clock);
         end_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.awaited_answers.size() != 0) begin
         $error("%0d search answers never arrived", tracker.awaited_answers.size());
         tracker.errors++;
      end

      $display("Ran %0d table writes and %0d searches (%0d hits), %0d answers checked,",
               tracker.writes_seen, tracker.searches_seen, tracker.hits_seen,
               tracker.answers_checked);
      $display("across %0d entry_count settings from empty to above the table size.",
               count_settings);
      if (tracker.errors == 0) begin
         $display("** rotated_sorted_search_core: PASSED **");
      end else begin
         $display("** rotated_sorted_search_core: FAILED **");
      end
      $finish;
   end

endmodule
